// ===== hw/rtl/wspd_pkg.sv =====
// shared types and constants for the weather sensor packet decoder
`default_nettype none

package wspd_pkg;

	localparam int unsigned CupWidth  = 7;
	localparam int unsigned RawWidth  = 10;
	localparam int unsigned DivWidth  = 23;
	localparam int unsigned MeasWidth = 24;
	localparam int unsigned CntWidth  = $clog2(DivWidth);

	localparam logic [CupWidth-1:0]  CupReset = 7'd20;
	localparam logic [MeasWidth-1:0] MeasSat  = 24'h7FFFFF;

	// message kinds from the header high nibble
	localparam logic [3:0] KindCap      = 4'd2;
	localparam logic [3:0] KindRainRate = 4'd5;
	localparam logic [3:0] KindSolar    = 4'd7;
	localparam logic [3:0] KindTemp     = 4'd8;
	localparam logic [3:0] KindGust     = 4'd9;
	localparam logic [3:0] KindHumid    = 4'd10;
	localparam logic [3:0] KindClicks   = 4'd14;

	// rain rate numerators for the two timing modes
	localparam logic [15:0] NumSlow = 16'd57600;
	localparam logic [15:0] NumFast = 16'd3600;

	// reciprocal multipliers, exact for the operand ranges used here
	localparam logic [18:0] Recip1000 = 19'd268436;     // shift 28
	localparam logic [12:0] Recip17   = 13'd7711;       // shift 17
	localparam logic [10:0] Recip5    = 11'd1639;       // shift 13
	localparam logic [26:0] TempMul   = 27'd116508500;  // 500 * ceil(2^21 / 9), shift 21

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_RECIP,
		ST_TEMP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic recip;
		logic temp;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wspd_pkt_if.sv =====
// packet input channel
`default_nettype none

interface wspd_pkt_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic [7:0] wind_speed_byte;
	logic [7:0] wind_direction_byte;
	logic [7:0] payload_high;
	logic [7:0] payload_low;

	modport source (
		output valid, header_byte, wind_speed_byte, wind_direction_byte,
		output payload_high, payload_low,
		input  ready
	);
	modport sink (
		input  valid, header_byte, wind_speed_byte, wind_direction_byte,
		input  payload_high, payload_low,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/wspd_res_if.sv =====
// decoded result channel
`default_nettype none

interface wspd_res_if;
	logic                                  valid;
	logic                                  ready;
	logic [2:0]                            station_id;
	logic                                  battery_low;
	logic [3:0]                            message_kind;
	logic [15:0]                           wind_speed;
	logic [8:0]                            wind_direction;
	logic signed [wspd_pkg::MeasWidth-1:0] measurement;
	logic                                  measurement_valid;
	logic                                  rate_saturated;
	logic [15:0]                           rain_clicks_day;
	logic [31:0]                           rain_clicks_total;

	modport source (
		output valid, station_id, battery_low, message_kind, wind_speed,
		output wind_direction, measurement, measurement_valid, rate_saturated,
		output rain_clicks_day, rain_clicks_total,
		input  ready
	);
	modport sink (
		input  valid, station_id, battery_low, message_kind, wind_speed,
		input  wind_direction, measurement, measurement_valid, rate_saturated,
		input  rain_clicks_day, rain_clicks_total,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/wspd_cfg_if.sv =====
// configuration write channel for the rain cup size
`default_nettype none

interface wspd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [wspd_pkg::CupWidth-1:0]      rain_cup_size;

	modport source (output valid, rain_cup_size, input ready);
	modport sink   (input valid, rain_cup_size, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wspd_div.sv =====
// bit-serial restoring divider for the rain rate
`default_nettype none

module wspd_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          step,
	input  wire logic [wspd_pkg::DivWidth-1:0] dividend,
	input  wire logic [wspd_pkg::RawWidth-1:0] divisor,
	output logic      [wspd_pkg::DivWidth-1:0] quotient
);

	logic [wspd_pkg::DivWidth-1:0] quo_q;
	logic [wspd_pkg::RawWidth-1:0] rem_q;
	logic [wspd_pkg::RawWidth-1:0] dvs_q;
	logic [wspd_pkg::RawWidth:0]   trial;
	logic [wspd_pkg::RawWidth:0]   rem_next;
	logic                          ge;

	// dividend bits shift out the top while quotient bits shift in below
	always_comb begin
		trial    = {rem_q, quo_q[wspd_pkg::DivWidth-1]};
		ge       = trial >= {1'b0, dvs_q};
		rem_next = ge ? trial - {1'b0, dvs_q} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
		end else if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step) begin
			quo_q <= {quo_q[wspd_pkg::DivWidth-2:0], ge};
			rem_q <= rem_next[wspd_pkg::RawWidth-1:0];
		end
	end

	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wspd_dp.sv =====
// datapath: field decode, constant scaling, rain tracking and result register
`default_nettype none

module wspd_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wspd_pkg::cmd_t                cmd,
	output wspd_pkg::sts_t                     sts,
	input  wire logic                          cfg_we,
	input  wire logic [wspd_pkg::CupWidth-1:0] cfg_data,
	wspd_pkt_if.sink                           pkt,
	wspd_res_if.source                         res
);

	// captured packet
	logic [7:0] hdr_q, ws_q, wd_q, b3_q, b4_q;
	logic [wspd_pkg::CupWidth-1:0] cup_q;

	// working registers
	logic [17:0]                   ws_y_q, gu_y_q;
	logic [12:0]                   dir_y_q;
	logic [10:0]                   t5_q;
	logic [wspd_pkg::DivWidth-1:0] rr_num_q;
	logic [15:0]                   wind_speed_q, gust_q;
	logic [8:0]                    dir_q;
	logic signed [9:0]             f_q;
	logic signed [wspd_pkg::MeasWidth-1:0] temp_q;

	// rain click tracking
	logic [6:0]  last_q;
	logic        have_q;
	logic [15:0] day_q;
	logic [31:0] total_q;

	// result register
	logic                                  out_valid_q;
	logic [2:0]                            station_id_q;
	logic                                  battery_low_q;
	logic [3:0]                            kind_out_q;
	logic [15:0]                           wind_speed_out_q;
	logic [8:0]                            dir_out_q;
	logic signed [wspd_pkg::MeasWidth-1:0] meas_q;
	logic                                  meas_valid_q;
	logic                                  sat_q;
	logic [15:0]                           day_out_q;
	logic [31:0]                           total_out_q;

	logic [3:0]                            kind;
	logic [wspd_pkg::RawWidth-1:0]         raw;
	logic [15:0]                           num;
	logic [36:0]                           ws_p, gu_p;
	logic [25:0]                           dir_p;
	logic [8:0]                            dir_d;
	logic [21:0]                           t_p;
	logic [8:0]                            q5;
	logic [9:0]                            f_neg;
	logic [8:0]                            mag;
	logic [35:0]                           tm_p;
	logic [14:0]                           tv;
	logic [wspd_pkg::DivWidth-1:0]         quotient;
	logic [9:0]                            cap;
	logic [11:0]                           humid;
	logic [6:0]                            click;
	logic [6:0]                            diff;
	logic [15:0]                           day_next;
	logic [31:0]                           total_next;
	logic signed [wspd_pkg::MeasWidth-1:0] meas_next;
	logic                                  meas_valid_next;
	logic                                  sat_next;
	logic                                  is_clicks;

	assign kind  = hdr_q[7:4];
	assign raw   = {b4_q[5:4], b3_q};
	assign num   = b4_q[6] ? wspd_pkg::NumFast : wspd_pkg::NumSlow;
	assign cap   = {b3_q, b4_q[7:6]};
	assign humid = {b4_q[7:4], b3_q};
	assign click = b3_q[6:0];

	assign sts.need_div = (kind == wspd_pkg::KindRainRate) && (b3_q != 8'hFF) && (raw != '0);
	assign sts.out_free = !out_valid_q || res.ready;

	wspd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.step     (cmd.div_step),
		.dividend (rr_num_q),
		.divisor  (raw),
		.quotient (quotient)
	);

	// reciprocal products: floor(y/1000), floor(y/17), floor(x/5), and the temperature magnitude scaling
	always_comb begin
		ws_p  = {19'd0, ws_y_q} * {18'd0, wspd_pkg::Recip1000};
		gu_p  = {19'd0, gu_y_q} * {18'd0, wspd_pkg::Recip1000};
		dir_p = {13'd0, dir_y_q} * {13'd0, wspd_pkg::Recip17};
		dir_d = dir_p[25:17];
		t_p   = {11'd0, t5_q} * {11'd0, wspd_pkg::Recip5};
		q5    = t_p[21:13];
		f_neg = -f_q;
		mag   = f_q[9] ? f_neg[8:0] : f_q[8:0];
		tm_p  = {27'd0, mag} * {9'd0, wspd_pkg::TempMul};
		tv    = tm_p[35:21];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cup_q <= wspd_pkg::CupReset;
		end else if (cfg_we) begin
			cup_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hdr_q <= pkt.header_byte;
			ws_q  <= pkt.wind_speed_byte;
			wd_q  <= pkt.wind_direction_byte;
			b3_q  <= pkt.payload_high;
			b4_q  <= pkt.payload_low;
		end
		if (cmd.prep) begin
			ws_y_q   <= {10'd0, ws_q} * 18'd934;
			gu_y_q   <= {10'd0, b3_q} * 18'd934;
			dir_y_q  <= {1'b0, wd_q, 4'b0} + {2'b0, wd_q, 3'b0};
			t5_q     <= {b3_q, b4_q[7:5]};
			rr_num_q <= {7'd0, num} * {16'd0, cup_q};
		end
		if (cmd.recip) begin
			// mph * 160.934 = mph * 160 + mph * 934 / 1000, in hundredths of km/h
			wind_speed_q <= {1'b0, ws_q, 7'b0} + {3'b0, ws_q, 5'b0} + {8'd0, ws_p[35:28]};
			gust_q       <= {1'b0, b3_q, 7'b0} + {3'b0, b3_q, 5'b0} + {8'd0, gu_p[35:28]};
			dir_q        <= (dir_d >= 9'd180) ? dir_d - 9'd180 : dir_d + 9'd180;
			f_q          <= $signed({1'b0, q5}) - 10'sd32;
		end
		if (cmd.temp) begin
			temp_q <= f_q[9] ? -$signed({9'd0, tv}) : $signed({9'd0, tv});
		end
	end

	// click tracker: first count seen gives a zero step
	always_comb begin
		is_clicks  = kind == wspd_pkg::KindClicks;
		diff       = have_q ? click - last_q : 7'd0;
		day_next   = day_q + {9'd0, diff};
		total_next = total_q + {25'd0, diff};
	end

	always_comb begin
		meas_next       = '0;
		meas_valid_next = 1'b1;
		sat_next        = 1'b0;
		unique case (kind)
			wspd_pkg::KindCap: begin
				meas_next = $signed({14'd0, cap});
			end
			wspd_pkg::KindRainRate: begin
				if (b3_q == 8'hFF) begin
					meas_next = '0;
				end else if (raw == '0) begin
					meas_next = $signed(wspd_pkg::MeasSat);
					sat_next  = 1'b1;
				end else begin
					meas_next = $signed({1'b0, quotient});
				end
			end
			wspd_pkg::KindSolar: begin
				meas_next = $signed({14'd0, cap} * 24'd100);
			end
			wspd_pkg::KindTemp: begin
				meas_next = temp_q;
			end
			wspd_pkg::KindGust: begin
				meas_next = $signed({8'd0, gust_q});
			end
			wspd_pkg::KindHumid: begin
				meas_next = $signed({12'd0, humid} * 24'd10);
			end
			wspd_pkg::KindClicks: begin
				meas_next = $signed({17'd0, click} * 24'd100);
			end
			default: begin
				meas_valid_next = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			have_q      <= 1'b0;
			day_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load && is_clicks) begin
				last_q  <= click;
				have_q  <= 1'b1;
				day_q   <= day_next;
				total_q <= total_next;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			station_id_q     <= hdr_q[2:0];
			battery_low_q    <= hdr_q[3];
			kind_out_q       <= kind;
			wind_speed_out_q <= wind_speed_q;
			dir_out_q        <= dir_q;
			meas_q           <= meas_next;
			meas_valid_q     <= meas_valid_next;
			sat_q            <= sat_next;
			day_out_q        <= is_clicks ? day_next : day_q;
			total_out_q      <= is_clicks ? total_next : total_q;
		end
	end

	assign res.valid             = out_valid_q;
	assign res.station_id        = station_id_q;
	assign res.battery_low       = battery_low_q;
	assign res.message_kind      = kind_out_q;
	assign res.wind_speed        = wind_speed_out_q;
	assign res.wind_direction    = dir_out_q;
	assign res.measurement       = meas_q;
	assign res.measurement_valid = meas_valid_q;
	assign res.rate_saturated    = sat_q;
	assign res.rain_clicks_day   = day_out_q;
	assign res.rain_clicks_total = total_out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wspd_ctrl.sv =====
// controller state machine sequencing the datapath
`default_nettype none

module wspd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pkt_valid,
	input  wire wspd_pkg::sts_t sts,
	output logic                in_ready,
	output wspd_pkg::cmd_t      cmd
);

	localparam logic [wspd_pkg::CntWidth-1:0] DivLast =
		wspd_pkg::CntWidth'(wspd_pkg::DivWidth - 1);

	wspd_pkg::state_t state_q, state_next;
	logic [wspd_pkg::CntWidth-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wspd_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			wspd_pkg::ST_IDLE: begin
				if (pkt_valid) state_next = wspd_pkg::ST_PREP;
			end
			wspd_pkg::ST_PREP: begin
				state_next = wspd_pkg::ST_RECIP;
			end
			wspd_pkg::ST_RECIP: begin
				state_next = wspd_pkg::ST_TEMP;
			end
			wspd_pkg::ST_TEMP: begin
				state_next = sts.need_div ? wspd_pkg::ST_DIV : wspd_pkg::ST_DONE;
			end
			wspd_pkg::ST_DIV: begin
				if (cnt_q == DivLast) state_next = wspd_pkg::ST_DONE;
			end
			wspd_pkg::ST_DONE: begin
				if (sts.out_free) state_next = wspd_pkg::ST_IDLE;
			end
			default: begin
				state_next = wspd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		unique case (state_q)
			wspd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = pkt_valid;
			end
			wspd_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
			end
			wspd_pkg::ST_RECIP: begin
				cmd.recip = 1'b1;
			end
			wspd_pkg::ST_TEMP: begin
				cmd.temp      = 1'b1;
				cmd.div_start = sts.need_div;
			end
			wspd_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			wspd_pkg::ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/weather_sensor_packet_decoder.sv =====
// Weather sensor packet decoder: takes the first five bytes of a sensor radio packet
// and returns one result word with station id, battery bit, message kind, wind speed
// in hundredths of km/h, wind direction rotated by 180 degrees, one measurement chosen
// by the kind, and the daily and overall rain click sums. One packet is worked on at a
// time. After a packet is accepted, the controller runs the prep, reciprocal and
// temperature states, then, for a rain rate packet that needs a division, the divider
// state, in which the bit-serial divider makes one quotient bit per cycle over 23
// bits, and at last the done state, which loads the result register. A new packet is
// accepted only after the previous one has been loaded there. The result sits in an
// output register, so the next packet is accepted while the previous word waits to be
// taken. The packet after that waits in its last step until the output register is
// free, and the input stays not ready meanwhile. The rain cup size register resets to
// 20 and is written through the cfg channel, which is always ready.
`default_nettype none

module weather_sensor_packet_decoder (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wspd_pkt_if.sink   pkt,
	wspd_res_if.source res,
	wspd_cfg_if.sink   cfg
);

	wspd_pkg::cmd_t cmd;
	wspd_pkg::sts_t sts;
	logic           in_ready;

	assign pkt.ready = in_ready;
	assign cfg.ready = 1'b1;

	wspd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt.valid),
		.sts       (sts),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	wspd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.rain_cup_size),
		.pkt      (pkt),
		.res      (res)
	);

endmodule

`default_nettype wire
